### src/rne_pkg.sv
// Shared types, codes and digit tables for the Roman numeral encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rne_pkg;

  localparam logic [2:0] SYM_I = 3'd0;
  localparam logic [2:0] SYM_V = 3'd1;
  localparam logic [2:0] SYM_X = 3'd2;
  localparam logic [2:0] SYM_L = 3'd3;
  localparam logic [2:0] SYM_C = 3'd4;
  localparam logic [2:0] SYM_D = 3'd5;
  localparam logic [2:0] SYM_M = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [9:0] MAX_VALUE = 10'd999;

  localparam logic [1:0] POS_HUND = 2'd0;
  localparam logic [1:0] POS_TENS = 2'd1;
  localparam logic [1:0] POS_ONES = 2'd2;
  localparam logic [1:0] POS_NONE = 2'd3;

  typedef enum logic [1:0] {
    ROLE_ONE,
    ROLE_FIVE,
    ROLE_TEN
  } role_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } rne_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rne_qstat_t;

  // Number of symbols that one decimal digit spells.
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] len;
    case (d)
      4'd0:    len = 3'd0;
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Role of the symbol at place idx within a digit.
  function automatic role_t digit_role(input logic [3:0] d, input logic [1:0] idx);
    role_t r;
    case (d)
      4'd4:                   r = (idx == 2'd0) ? ROLE_ONE : ROLE_FIVE;
      4'd9:                   r = (idx == 2'd0) ? ROLE_ONE : ROLE_TEN;
      4'd5, 4'd6, 4'd7, 4'd8: r = (idx == 2'd0) ? ROLE_FIVE : ROLE_ONE;
      default:                r = ROLE_ONE;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] role_symbol(input logic [1:0] pos, input role_t r);
    logic [2:0] s;
    case (pos)
      POS_HUND: s = (r == ROLE_ONE) ? SYM_C : (r == ROLE_FIVE) ? SYM_D : SYM_M;
      POS_TENS: s = (r == ROLE_ONE) ? SYM_X : (r == ROLE_FIVE) ? SYM_L : SYM_C;
      POS_ONES: s = (r == ROLE_ONE) ? SYM_I : (r == ROLE_FIVE) ? SYM_V : SYM_X;
      default:  s = SYM_I;
    endcase
    return s;
  endfunction

endpackage

### src/rne_front.sv
// Front end: takes a command, classifies it and splits it into decimal digits.
// Depends on rne_pkg; pushes finished items into rne_queue.
`timescale 1ns / 1ps

module rne_front
  import rne_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [9:0] in_value,
  output logic       busy,
  input  logic       q_full,
  output logic       push,
  output rne_item_t  push_item
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_status_r;
  logic [3:0] s1_hund_r;
  logic [6:0] s1_rem_r;

  logic       take;
  logic [3:0] hund;
  logic [9:0] hund_w;
  logic [3:0] tens;
  logic [6:0] tens_w;

  assign busy = s1_valid_r && q_full;
  assign take = start && !busy;
  assign push = s1_valid_r && !q_full;

  always_comb begin
    hund = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (in_value >= 10'(k * 100)) begin
        hund = 4'(k);
      end
    end
    hund_w = 10'(hund) * 10'd100;
  end

  always_comb begin
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (s1_rem_r >= 7'(k * 10)) begin
        tens = 4'(k);
      end
    end
    tens_w = 7'(tens) * 7'd10;
  end

  assign push_item.status = s1_status_r;
  assign push_item.hund   = s1_hund_r;
  assign push_item.tens   = tens;
  assign push_item.ones   = 4'(s1_rem_r - tens_w);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (in_value > MAX_VALUE) begin
        s1_status_r <= ST_RANGE;
      end else if (in_value == 10'd0) begin
        s1_status_r <= ST_ZERO;
      end else begin
        s1_status_r <= ST_OK;
      end
      s1_hund_r <= hund;
      s1_rem_r  <= 7'(in_value - hund_w);
    end
  end

endmodule

### src/rne_queue.sv
// Two-entry queue of digit items between the front and back ends.
// Depends on rne_pkg for the item and status types.
`timescale 1ns / 1ps

module rne_queue
  import rne_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rne_item_t  push_item,
  input  logic       pop,
  output rne_item_t  head,
  output rne_qstat_t stat
);

  rne_item_t  mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

### src/rne_back.sv
// Back end: walks the digits of one item and emits one symbol per cycle.
// Depends on rne_pkg for digit tables and codes; pops items from rne_queue.
`timescale 1ns / 1ps

module rne_back
  import rne_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  rne_item_t  head,
  output logic       pop,
  output logic       out_strobe,
  output logic [2:0] out_symbol,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic       active_r, active_nxt;
  logic [1:0] status_r;
  logic [3:0] hund_r, tens_r, ones_r;
  logic [1:0] pos_r, pos_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic [3:0] cur;
  logic [2:0] len;
  logic       digit_end;
  logic [1:0] next_pos;
  logic [1:0] load_pos;
  logic       is_last;

  always_comb begin
    case (pos_r)
      POS_HUND: cur = hund_r;
      POS_TENS: cur = tens_r;
      POS_ONES: cur = ones_r;
      default:  cur = 4'd0;
    endcase
  end

  assign len       = digit_len(cur);
  assign digit_end = ({1'b0, idx_r} == len - 3'd1);

  always_comb begin
    next_pos = POS_NONE;
    if (pos_r == POS_HUND && tens_r != 4'd0) begin
      next_pos = POS_TENS;
    end else if ((pos_r == POS_HUND || pos_r == POS_TENS) && ones_r != 4'd0) begin
      next_pos = POS_ONES;
    end
  end

  always_comb begin
    if (head.hund != 4'd0) begin
      load_pos = POS_HUND;
    end else if (head.tens != 4'd0) begin
      load_pos = POS_TENS;
    end else begin
      load_pos = POS_ONES;
    end
  end

  assign is_last = (status_r != ST_OK) || (digit_end && next_pos == POS_NONE);
  assign pop     = !q_empty && (!active_r || is_last);

  assign out_strobe = active_r;
  assign out_status = status_r;
  assign out_last   = is_last;
  assign out_symbol = (status_r == ST_OK) ? role_symbol(pos_r, digit_role(cur, idx_r)) : SYM_I;

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    if (pop) begin
      active_nxt = 1'b1;
      pos_nxt    = load_pos;
      idx_nxt    = 2'd0;
    end else if (active_r && is_last) begin
      active_nxt = 1'b0;
    end else if (active_r && digit_end) begin
      pos_nxt = next_pos;
      idx_nxt = 2'd0;
    end else if (active_r) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    if (pop) begin
      status_r <= head.status;
      hund_r   <= head.hund;
      tens_r   <= head.tens;
      ones_r   <= head.ones;
    end
  end

endmodule

### src/roman_numeral_encoder_unit.sv
// Top level of the Roman numeral encoder: front end, item queue, back end.
// Depends on rne_pkg, rne_front, rne_queue and rne_back.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive in_value and raise start; the command transfers at
//   a rising edge where start is high and busy is low.
//   Result channel: each result sits on out_symbol, out_status and out_last
//   for one cycle with out_strobe high. The receiver cannot stall, so every
//   strobed cycle is a transfer.
//   Values 1..999 give 1 to 12 symbols, most significant first, out_last on
//   the final one. Zero gives one result with status "zero", values above
//   999 one result with status "out of range"; symbol is 0 for both.
// Path: a command passes the front stage register, then the queue, then the
//   back end registers, which drive the first result onto the ports.
// Throughput: the back end emits one symbol per cycle, so a command occupies
//   it for as many symbols as its numeral has (1 to 12); the front end splits
//   digits in two stages and a two-entry queue lets it run ahead, so busy
//   only rises once the queue and the front stage are both full.
// Reset: synchronous, active low; drops all queued and in-flight commands.

module roman_numeral_encoder_unit
  import rne_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [9:0] in_value,
  output logic       busy,
  output logic       out_strobe,
  output logic [2:0] out_symbol,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic       push;
  logic       pop;
  rne_item_t  push_item;
  rne_item_t  head;
  rne_qstat_t qstat;

  rne_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_value  (in_value),
    .busy      (busy),
    .q_full    (qstat.full),
    .push      (push),
    .push_item (push_item)
  );

  rne_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  rne_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (qstat.empty),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_symbol (out_symbol),
    .out_status (out_status),
    .out_last   (out_last)
  );

  a_special_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_last && out_symbol == SYM_I))
    else $error("special status result must be a single zero symbol");

  a_numeral_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> (out_strobe && out_status == ST_OK))
    else $error("numeral interrupted before its last symbol");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("back end popped an empty queue");

endmodule
